// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, held off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== rtl/plt_pkg.sv =====
package plt_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_CHANNELS = 8;
  localparam int CH_TOP       = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
  localparam int MEM_DEPTH    = MAX_ROWS * MAX_CHANNELS;
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int CNT_W        = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int NACT_W       = 4;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 120;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;
  localparam int DIV_STEPS    = 64;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRAP_ERR = 1'd1;

  localparam logic signed [49:0] S48_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] S48_MIN = 50'sh3_8000_0000_0000;
  localparam logic [63:0] S32_POS_LIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] S32_NEG_LIM = 64'h0000_0000_8000_0000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_HELD_LO  = 3'd1,
    STS_HELD_HI  = 3'd2,
    STS_RANGE    = 3'd3,
    STS_NOT_INC  = 3'd4,
    STS_FULL     = 3'd5,
    STS_EMPTY    = 3'd6,
    STS_CH_ORDER = 3'd7
  } status_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    logic signed [49:0] y;
    y = x;
    if (x > S48_MAX) y = S48_MAX;
    if (x < S48_MIN) y = S48_MIN;
    return 48'(y);
  endfunction

  function automatic logic [ADDR_W-1:0] row_addr(input logic [ROW_W-1:0] row,
                                                 input logic [2:0] ch);
    return ADDR_W'(row) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch);
  endfunction

endpackage

// ===== rtl/plt_mul.sv =====
module plt_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [63:0] prod_r
);
  import plt_pkg::*;

  logic [65:0] full;

  assign full = a * b;

  // keep the low 64 bits, as a wrapping magnitude product
  always_ff @(posedge clk) begin
    prod_r <= full[63:0];
  end

endmodule

// ===== rtl/plt_div.sv =====
`include "assert_macros.svh"

module plt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  plt_pkg::div_req_t req,
  output plt_pkg::div_rsp_t rsp
);
  import plt_pkg::*;

  logic [31:0]          rem_r;
  logic [63:0]          dq_r;
  logic [31:0]          dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [32:0]          rem_sh;
  logic [32:0]          rem_sub;
  logic                 ge;

  // restoring step: one quotient bit per cycle
  assign rem_sh  = {rem_r, dq_r[63]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dq_r  <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dq_r  <= {dq_r[62:0], ge};
    end
  end

  assign rsp = '{busy: busy_r, done: done_r, quot: dq_r};

  `ASSERT_CLK(a_div_no_restart, !(req.start && busy_r), "divider restarted mid run")
  `ASSERT_CLK(a_div_done_after_busy, done_r |-> $past(busy_r), "divider done without a run")
  `ASSERT_NEXT(a_div_done_pulse, done_r, !done_r && !busy_r, "divider done held or rerun")

endmodule

// ===== rtl/piecewise_linear_time_table_top.sv =====
// Piecewise linear time table. Send requests on in_*: op in in_tuser (0 clear, 1 append one
// channel sample, 2 query). Appends come in channel order 0 upward, with the row time given on
// channel 0; a row is visible to queries once its last active channel is in. Each request
// gets one result, except a query in range or held, which gets one result per active channel,
// out_tlast marking the final one; op 3 is dropped with no result. One request is taken at a
// time; clear and a rejected append go straight to the result, an accepted append after the
// first row adds a read and a multiply. A query inside the table binary-searches the row
// times (S_BS, S_BS_CMP per halving), then per channel runs the shared one-bit-per-cycle
// 64-step divider twice (value and slope); held end values skip it. The result register lets
// the next request in while a result waits. Write configuration (cfg_*) only while idle; the
// block does not enforce it. Writing active_channels clears the table.
`include "assert_macros.svh"

module piecewise_linear_time_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // time_req[31:0], channel[34:32], sample[66:35], zero fill above
  input  logic [plt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_channel[2:0], interp_value[34:3], slope[66:35], running_integral[114:67], zero fill
  output logic [plt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_wen,
  input  logic [plt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import plt_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DEC     = 18'h00002,
    S_APP_RD  = 18'h00004,
    S_APP_MUL = 18'h00008,
    S_BS      = 18'h00010,
    S_BS_CMP  = 18'h00020,
    S_Q_RD    = 18'h00040,
    S_Q_HOLD  = 18'h00080,
    S_Q_HMUL  = 18'h00100,
    S_Q_RD2   = 18'h00200,
    S_Q_V1    = 18'h00400,
    S_Q_DIV1  = 18'h00800,
    S_Q_DW1   = 18'h01000,
    S_Q_DIV2  = 18'h02000,
    S_Q_DW2   = 18'h04000,
    S_Q_M3    = 18'h08000,
    S_Q_IMUL  = 18'h10000,
    S_EMIT    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic [CNT_W-1:0]  row_count_r;
  logic [2:0]        next_ch_r;
  logic [NACT_W-1:0] nact_r;
  logic              ext_err_r;
  logic              out_tvalid_r;

  // request and working registers
  op_t                 op_r;
  logic signed [31:0]  t_r, s_r;
  logic [2:0]          ch_r, n_r;
  logic signed [31:0]  t_first_r, t_last_r, t_cur_r;
  logic signed [31:0]  t_lo_r, t_hi_r, rt_lo_q;
  logic [ROW_W-1:0]    lo_r, hi_r, mid_r;
  logic                hold_r, neg_r, diff_neg_r;
  status_t             q_sts_r;
  logic signed [31:0]  v0_r, val_r;
  logic signed [47:0]  p_r;
  logic [32:0]         absdiff_r;
  logic [31:0]         slope_r;

  // staged result
  logic [2:0]          res_ch_r;
  logic [31:0]         res_val_r, res_slope_r;
  logic [47:0]         res_integ_r;
  status_t             res_sts_r;
  logic                res_last_r;

  logic [OUT_TDATA_W-1:0] out_tdata_r;
  status_t                out_tuser_r;
  logic                   out_tlast_r;

  // table storage
  logic signed [31:0] rt_mem [MAX_ROWS];
  logic signed [31:0] rs_mem [MEM_DEPTH];
  logic signed [47:0] pf_mem [MEM_DEPTH];
  logic signed [31:0] rs_q;
  logic signed [47:0] pf_q;
  logic               rt_we, rs_we, pf_we;
  logic [ROW_W-1:0]   rt_raddr;
  logic [ADDR_W-1:0]  rs_raddr, wr_addr;
  logic signed [47:0] pf_wdata;

  // shared arithmetic
  logic [32:0]        mul_a, mul_b;
  logic [63:0]        prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               accept, slot_free, advance, last_c;
  logic [ROW_W-1:0]   rc_m1, mid_c;
  status_t            app_sts;
  logic               q_below, q_above, q_empty;
  logic signed [32:0] app_sum, app_dt, off, diff_c, vsum;
  logic [47:0]        m48;
  logic signed [49:0] m50, term50;
  logic signed [47:0] integ_c;
  logic [31:0]        slope_c;
  logic [NACT_W-1:0]  nact_wr;

  plt_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  plt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  assign rc_m1  = ROW_W'(row_count_r - CNT_W'(1));
  assign mid_c  = lo_r + ((hi_r - lo_r) >> 1);
  assign last_c = (NACT_W'(n_r) + NACT_W'(1)) == nact_r;

  // append checks: order first, then full, then time not increasing
  always_comb begin
    app_sts = STS_OK;
    if (ch_r != next_ch_r) begin
      app_sts = STS_CH_ORDER;
    end else if (ch_r == 3'd0 && row_count_r >= CNT_W'(MAX_ROWS)) begin
      app_sts = STS_FULL;
    end else if (ch_r == 3'd0 && row_count_r != '0 && t_r <= t_last_r) begin
      app_sts = STS_NOT_INC;
    end
  end

  assign q_empty = (row_count_r == '0);
  assign q_below = t_r < t_first_r;
  assign q_above = t_r > t_last_r;

  assign app_sum = 33'(rs_q) + 33'(s_r);
  assign app_dt  = 33'(t_cur_r) - 33'(t_last_r);
  assign off     = 33'(t_r) - 33'(t_lo_r);
  assign diff_c  = 33'(rs_q) - 33'(v0_r);
  assign vsum    = 33'(v0_r) + 33'(val_r);

  // integral term: the held case scales by 2^-16, the trapezoid by 2^-17
  assign m48     = (state_r == S_Q_HMUL) ? prod[63:16] : {1'b0, prod[63:17]};
  assign m50     = {2'b00, m48};
  assign term50  = neg_r ? -m50 : m50;
  assign integ_c = sat48(50'(p_r) + term50);

  always_comb begin
    if (!diff_neg_r) begin
      slope_c = (div_rsp.quot > S32_POS_LIM) ? S32_POS_LIM[31:0] : div_rsp.quot[31:0];
    end else begin
      slope_c = (div_rsp.quot > S32_NEG_LIM) ? S32_NEG_LIM[31:0] : -div_rsp.quot[31:0];
    end
  end

  always_comb begin
    nact_wr = cfg_wdata;
    if (cfg_wdata == '0) nact_wr = NACT_W'(1);
    if (cfg_wdata > NACT_W'(CH_TOP)) nact_wr = NACT_W'(CH_TOP);
  end

  assign wr_addr = row_addr(row_count_r[ROW_W-1:0], ch_r);

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    mul_a            = '0;
    mul_b            = '0;
    rt_we            = 1'b0;
    rs_we            = 1'b0;
    pf_we            = 1'b0;
    pf_wdata         = integ_c;
    rs_raddr         = '0;
    rt_raddr         = mid_c;
    advance          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = 32'(t_hi_r - t_lo_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DEC;
      end
      S_DEC: begin
        unique case (op_r)
          OP_CLEAR: state_nxt = S_EMIT;
          OP_APPEND: begin
            state_nxt = S_EMIT;
            if (app_sts == STS_OK) begin
              rt_we = (ch_r == 3'd0);
              if (row_count_r == '0) begin
                // first row: prefix integral starts at zero
                rs_we    = 1'b1;
                pf_we    = 1'b1;
                pf_wdata = '0;
                advance  = 1'b1;
              end else begin
                rs_raddr  = row_addr(rc_m1, ch_r);
                state_nxt = S_APP_RD;
              end
            end
          end
          OP_QUERY: begin
            if (q_empty || ((q_below || q_above) && ext_err_r)) begin
              state_nxt = S_EMIT;
            end else if (q_below || q_above || row_count_r == CNT_W'(1)) begin
              state_nxt = S_Q_RD;
            end else begin
              state_nxt = S_BS;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_APP_RD: begin
        mul_a     = mag33(app_dt);
        mul_b     = mag33(app_sum);
        state_nxt = S_APP_MUL;
      end
      S_APP_MUL: begin
        rs_we     = 1'b1;
        pf_we     = 1'b1;
        advance   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_BS: begin
        state_nxt = (hi_r - lo_r > ROW_W'(1)) ? S_BS_CMP : S_Q_RD;
      end
      S_BS_CMP: state_nxt = S_BS;
      S_Q_RD: begin
        rs_raddr  = row_addr(lo_r, n_r);
        state_nxt = hold_r ? S_Q_HOLD : S_Q_RD2;
      end
      S_Q_HOLD: begin
        mul_a     = mag33(off);
        mul_b     = mag33(33'(rs_q));
        state_nxt = S_Q_HMUL;
      end
      S_Q_HMUL: state_nxt = S_EMIT;
      S_Q_RD2: begin
        rs_raddr  = row_addr(lo_r + ROW_W'(1), n_r);
        state_nxt = S_Q_V1;
      end
      S_Q_V1: begin
        mul_a     = mag33(diff_c);
        mul_b     = mag33(off);
        state_nxt = S_Q_DIV1;
      end
      S_Q_DIV1: begin
        div_req.start = 1'b1;
        state_nxt     = S_Q_DW1;
      end
      S_Q_DW1: begin
        if (div_rsp.done) state_nxt = S_Q_DIV2;
      end
      S_Q_DIV2: begin
        div_req.start    = 1'b1;
        div_req.dividend = {15'd0, absdiff_r, 16'd0};
        state_nxt        = S_Q_DW2;
      end
      S_Q_DW2: begin
        if (div_rsp.done) state_nxt = S_Q_M3;
      end
      S_Q_M3: begin
        mul_a     = mag33(off);
        mul_b     = mag33(vsum);
        state_nxt = S_Q_IMUL;
      end
      S_Q_IMUL: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) state_nxt = res_last_r ? S_IDLE : S_Q_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (rt_we) rt_mem[row_count_r[ROW_W-1:0]] <= t_r;
    rt_lo_q <= rt_mem[rt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[wr_addr] <= s_r;
    rs_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk) begin
    if (pf_we) pf_mem[wr_addr] <= pf_wdata;
    pf_q <= pf_mem[rs_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_count_r  <= '0;
      next_ch_r    <= '0;
      nact_r       <= NACT_W'(1);
      ext_err_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && slot_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_ACTIVE_CH: begin
            nact_r      <= nact_wr;
            row_count_r <= '0;
            next_ch_r   <= '0;
          end
          REG_EXTRAP_ERR: ext_err_r <= cfg_wdata[0];
          default: ext_err_r <= ext_err_r;
        endcase
      end else if (state_r == S_DEC && op_r == OP_CLEAR) begin
        row_count_r <= '0;
        next_ch_r   <= '0;
      end else if (advance) begin
        // close the row after its last active channel
        if (NACT_W'(ch_r) + NACT_W'(1) >= nact_r) begin
          next_ch_r   <= '0;
          row_count_r <= row_count_r + CNT_W'(1);
        end else begin
          next_ch_r <= ch_r + 3'd1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_t'(in_tuser);
      t_r  <= in_tdata[31:0];
      ch_r <= in_tdata[34:32];
      s_r  <= in_tdata[66:35];
    end
    if (advance && NACT_W'(ch_r) + NACT_W'(1) >= nact_r) begin
      t_last_r <= (ch_r == 3'd0) ? t_r : t_cur_r;
    end
    unique case (state_r)
      S_DEC: begin
        res_ch_r    <= '0;
        res_val_r   <= '0;
        res_slope_r <= '0;
        res_integ_r <= '0;
        res_sts_r   <= STS_OK;
        res_last_r  <= 1'b1;
        n_r         <= '0;
        unique case (op_r)
          OP_APPEND: begin
            res_ch_r  <= ch_r;
            res_sts_r <= app_sts;
            if (app_sts == STS_OK && ch_r == 3'd0) begin
              t_cur_r <= t_r;
              if (row_count_r == '0) t_first_r <= t_r;
            end
          end
          OP_QUERY: begin
            if (q_empty) begin
              res_sts_r <= STS_EMPTY;
            end else if ((q_below || q_above) && ext_err_r) begin
              res_sts_r <= STS_RANGE;
            end
            hold_r  <= q_below || q_above || row_count_r == CNT_W'(1);
            q_sts_r <= q_below ? STS_HELD_LO : (q_above ? STS_HELD_HI : STS_OK);
            hi_r    <= rc_m1;
            t_hi_r  <= t_last_r;
            if (q_below || q_above || row_count_r == CNT_W'(1)) begin
              lo_r   <= q_below ? '0 : rc_m1;
              t_lo_r <= q_below ? t_first_r : t_last_r;
            end else begin
              lo_r   <= '0;
              t_lo_r <= t_first_r;
            end
          end
          default: res_sts_r <= STS_OK;
        endcase
      end
      S_APP_RD: begin
        p_r   <= pf_q;
        neg_r <= app_sum[32];
      end
      S_BS: mid_r <= mid_c;
      S_BS_CMP: begin
        // narrow the bracket around the query time
        if (rt_lo_q <= t_r) begin
          lo_r   <= mid_r;
          t_lo_r <= rt_lo_q;
        end else begin
          hi_r   <= mid_r;
          t_hi_r <= rt_lo_q;
        end
      end
      S_Q_HOLD: begin
        v0_r  <= rs_q;
        p_r   <= pf_q;
        neg_r <= off[32] ^ rs_q[31];
      end
      S_Q_HMUL: begin
        res_ch_r    <= n_r;
        res_val_r   <= v0_r;
        res_slope_r <= '0;
        res_integ_r <= integ_c;
        res_sts_r   <= q_sts_r;
        res_last_r  <= last_c;
      end
      S_Q_RD2: begin
        v0_r <= rs_q;
        p_r  <= pf_q;
      end
      S_Q_V1: begin
        absdiff_r  <= mag33(diff_c);
        diff_neg_r <= diff_c[32];
      end
      S_Q_DW1: begin
        if (div_rsp.done) begin
          val_r <= diff_neg_r ? v0_r - div_rsp.quot[31:0] : v0_r + div_rsp.quot[31:0];
        end
      end
      S_Q_DW2: begin
        if (div_rsp.done) slope_r <= slope_c;
      end
      S_Q_M3: neg_r <= vsum[32];
      S_Q_IMUL: begin
        res_ch_r    <= n_r;
        res_val_r   <= val_r;
        res_slope_r <= slope_r;
        res_integ_r <= integ_c;
        res_sts_r   <= q_sts_r;
        res_last_r  <= last_c;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_tdata_r <= {5'd0, res_integ_r, res_slope_r, res_val_r, res_ch_r};
          out_tuser_r <= res_sts_r;
          out_tlast_r <= res_last_r;
          if (!res_last_r) n_r <= n_r + 3'd1;
        end
      end
      default: mid_r <= mid_r;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `ASSERT_CLK(a_rows_bound, row_count_r <= CNT_W'(MAX_ROWS), "row count beyond table depth")
  `ASSERT_CLK(a_next_ch, NACT_W'(next_ch_r) < nact_r, "expected channel past active count")
  `ASSERT_CLK(a_idle_div, in_tready |-> !div_rsp.busy, "request taken while divider runs")
  `ASSERT_NEXT(a_emit_loads, state_r == S_EMIT && slot_free, out_tvalid_r, "result not loaded")

endmodule

// ===== verif/piecewise_linear_time_table_top_tb.sv =====
`timescale 1ns / 100ps

module piecewise_linear_time_table_top_tb;
  import plt_pkg::*;

  localparam int  RUN_LIMIT  = 3000000;
  localparam int  SETTLE     = 2000;
  localparam int  RAND_ITEMS = 10;

  typedef struct {
    logic [2:0]         ch;
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic signed [47:0] integ;
    status_t            status;
    logic               last;
  } plt_result_t;

  // Table predictor: holds its own copy of the rows and registers, and the queue of results
  // still owed by the block.
  class plt_table_sb;
    longint      row_t[MAX_ROWS];
    longint      row_s[MAX_ROWS * MAX_CHANNELS];
    longint      row_int[MAX_ROWS * MAX_CHANNELS];
    int          rows;
    int          next_ch;
    int          act_reg;
    bit          err_mode;
    plt_result_t owed[$];
    int          errors;

    function new();
      rows = 0;
      next_ch = 0;
      act_reg = 1;
      err_mode = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function int chans();
      int n;
      n = act_reg;
      if (n < 1) n = 1;
      if (n > CH_TOP) n = CH_TOP;
      return n;
    endfunction

    // Product over divisor, truncated toward zero; the product wraps at 64 bits.
    function longint scale_tz(longint a, longint b, longint unsigned d);
      longint unsigned ma, mb, m;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb) / d;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint clip48(longint x);
      if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return x;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
    endfunction

    function void owe(int ch, longint v, longint sl, longint ig, status_t st, bit last);
      plt_result_t r;
      r.ch = ch[2:0];
      r.value = v[31:0];
      r.slope = sl[31:0];
      r.integ = ig[47:0];
      r.status = st;
      r.last = last;
      owed = {owed, r};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ACTIVE_CH) begin
        act_reg = val;
        rows = 0;
        next_ch = 0;
      end else begin
        err_mode = val[0];
      end
    endfunction

    function void append(longint t, int ch, longint s);
      int at;
      longint term;
      if (ch != next_ch) begin
        owe(ch, 0, 0, 0, STS_CH_ORDER, 1);
        return;
      end
      if (ch == 0 && rows >= MAX_ROWS) begin
        owe(ch, 0, 0, 0, STS_FULL, 1);
        return;
      end
      if (ch == 0 && rows > 0 && t <= row_t[rows-1]) begin
        owe(ch, 0, 0, 0, STS_NOT_INC, 1);
        return;
      end
      at = rows * MAX_CHANNELS + ch;
      if (ch == 0) row_t[rows] = t;
      row_s[at] = s;
      if (rows == 0) begin
        row_int[at] = 0;
      end else begin
        term = scale_tz(row_t[rows] - row_t[rows-1], row_s[at-MAX_CHANNELS] + s, 2 * 65536);
        row_int[at] = clip48(row_int[at-MAX_CHANNELS] + term);
      end
      if (ch + 1 >= chans()) begin
        next_ch = 0;
        rows++;
      end else begin
        next_ch = ch + 1;
      end
      owe(ch, 0, 0, 0, STS_OK, 1);
    endfunction

    function void query(longint t);
      int     lo, hi, mid, a, b, nact, seg;
      bit     below, above;
      longint t0, tl, v0, diff, val, span, off;
      nact = chans();
      if (rows == 0) begin
        owe(0, 0, 0, 0, STS_EMPTY, 1);
        return;
      end
      t0 = row_t[0];
      tl = row_t[rows-1];
      below = t < t0;
      above = t > tl;
      if ((below || above) && err_mode) begin
        owe(0, 0, 0, 0, STS_RANGE, 1);
        return;
      end
      seg = 0;
      if (!below && !above && rows >= 2) begin
        if (t >= tl) begin
          seg = rows - 2;
        end else begin
          lo = 0;
          hi = rows - 1;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (row_t[mid] <= t) lo = mid;
            else hi = mid;
          end
          seg = lo;
        end
      end
      for (int n = 0; n < nact; n++) begin
        if (below) begin
          owe(n, row_s[n], 0, clip48(scale_tz(t - t0, row_s[n], 65536)), STS_HELD_LO,
              n + 1 == nact);
        end else if (above) begin
          a = (rows - 1) * MAX_CHANNELS + n;
          owe(n, row_s[a], 0, clip48(row_int[a] + scale_tz(t - tl, row_s[a], 65536)),
              STS_HELD_HI, n + 1 == nact);
        end else if (rows == 1) begin
          owe(n, row_s[n], 0, row_int[n], STS_OK, n + 1 == nact);
        end else begin
          a = seg * MAX_CHANNELS + n;
          b = a + MAX_CHANNELS;
          span = row_t[seg+1] - row_t[seg];
          off = t - row_t[seg];
          v0 = row_s[a];
          diff = row_s[b] - v0;
          val = v0 + scale_tz(diff, off, span);
          owe(n, val, clip32(scale_tz(diff, 65536, span)),
              clip48(row_int[a] + scale_tz(off, v0 + val, 2 * 65536)), STS_OK, n + 1 == nact);
        end
      end
    endfunction

    // Note one accepted request and queue what it must produce.
    function void note_request(op_t op, logic [31:0] t, logic [2:0] ch, logic [31:0] s);
      case (op)
        OP_CLEAR: begin
          rows = 0;
          next_ch = 0;
          owe(0, 0, 0, 0, STS_OK, 1);
        end
        OP_APPEND: append(longint'($signed(t)), ch, longint'($signed(s)));
        OP_QUERY:  query(longint'($signed(t)));
        default: ;
      endcase
    endfunction

    // Compare one result with the oldest owed one, field by field.
    task check_result(plt_result_t got);
      plt_result_t exp_r;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result ch %0d status %0d", got.ch, got.status));
        return;
      end
      exp_r = owed.pop_front();
      if (got.ch !== exp_r.ch)
        report($sformatf("channel %0d, want %0d", got.ch, exp_r.ch));
      if (got.value !== exp_r.value)
        report($sformatf("ch %0d value %h, want %h", exp_r.ch, got.value, exp_r.value));
      if (got.slope !== exp_r.slope)
        report($sformatf("ch %0d slope %h, want %h", exp_r.ch, got.slope, exp_r.slope));
      if (got.integ !== exp_r.integ)
        report($sformatf("ch %0d integral %h, want %h", exp_r.ch, got.integ, exp_r.integ));
      if (got.status !== exp_r.status)
        report($sformatf("ch %0d status %0d, want %0d", exp_r.ch, got.status, exp_r.status));
      if (got.last !== exp_r.last)
        report($sformatf("ch %0d last %0d, want %0d", exp_r.ch, got.last, exp_r.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_wen;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  plt_table_sb sb = new();
  int          send_idle;   // percent of cycles the sender holds off
  int          recv_idle;   // percent of cycles the receiver stalls
  int          cycles;

  piecewise_linear_time_table_top u_top (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result side at random; at zero percent it never stalls.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Take each result at the rising edge it is accepted.
  always @(posedge clk) begin
    plt_result_t r;
    if (rst_n && out_tvalid && out_tready) begin
      r.ch = out_tdata[2:0];
      r.value = out_tdata[34:3];
      r.slope = out_tdata[66:35];
      r.integ = out_tdata[114:67];
      r.status = status_t'(out_tuser);
      r.last = out_tlast;
      sb.check_result(r);
    end
  end

  // Watchdog: abandon the run well past the slowest legal finish.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("piecewise_linear_time_table_top_tb NOT OK");
      $finish;
    end
  end

  // Present one request, idling first at random, and hold it until accepted. Valid stays high
  // between back-to-back requests so it is never dropped and raised in the same step.
  task automatic send(op_t op, logic [31:0] t, logic [2:0] ch, logic [31:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'd0, s, ch, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, t, ch, s);
  endtask

  // Drop valid, then wait for every owed result and let the block settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_sample();
    if ($urandom_range(1)) return $urandom;
    return 32'($urandom_range(1 << 20)) - 32'(1 << 19);
  endfunction

  // Pick a query time: mostly inside the table, sometimes on a breakpoint or outside.
  function automatic logic [31:0] pick_query_time();
    longint      t0, tl;
    int unsigned k;
    if (sb.rows == 0) return $urandom;
    t0 = sb.row_t[0];
    tl = sb.row_t[sb.rows-1];
    k = $urandom_range(9);
    if (k < 5)  return 32'(t0 + longint'({$urandom, $urandom} % 64'(tl - t0 + 1)));
    if (k < 7)  return 32'(sb.row_t[$urandom_range(sb.rows - 1)]);
    if (k == 7) return $urandom;
    if (k == 8) return 32'(t0 - longint'($urandom_range(1 << 16)));
    return 32'(tl + longint'($urandom_range(1 << 16)));
  endfunction

  // Random phase: mostly well-formed row building and queries, some noise.
  task automatic random_phase(int items);
    int          k;
    longint      t;
    logic [31:0] tq;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        tq = $urandom;
        if (sb.next_ch == 0 && sb.rows > 0) begin
          t = sb.row_t[sb.rows-1] +
              (($urandom_range(3) == 0) ? longint'($urandom) : longint'($urandom_range(1 << 18)));
          tq = (t > 64'sh7FFF_FFFF) ? $urandom : 32'(t);
        end
        send(OP_APPEND, tq, sb.next_ch[2:0], pick_sample());
      end else if (k < 88) begin
        send(OP_QUERY, pick_query_time(), 3'($urandom), $urandom);
      end else if (k < 91) begin
        send(OP_CLEAR, $urandom, 3'($urandom), $urandom);
      end else if (k < 95) begin
        send(OP_NONE, $urandom, 3'($urandom), $urandom);
      end else begin
        send(OP_APPEND, $urandom, 3'($urandom), $urandom);
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_CLEAR;
    out_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = REG_ACTIVE_CH;
    cfg_wdata = '0;
    cycles = 0;
    send_idle = 13;
    recv_idle = 79;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: three channels, edge times and samples, every status but full.
    write_cfg(REG_ACTIVE_CH, 4'd3);
    write_cfg(REG_EXTRAP_ERR, 4'd0);
    send(OP_QUERY, 32'h0, 3'd0, 32'h0);                     // empty table
    send(OP_APPEND, 32'h0, 3'd1, 32'h1);                    // out of channel order
    send(OP_APPEND, 32'h8000_0000, 3'd0, 32'h7FFF_FFFF);
    send(OP_APPEND, 32'h1234_5678, 3'd1, 32'h8000_0000);    // time ignored off channel 0
    send(OP_APPEND, 32'h0, 3'd2, 32'h0);
    send(OP_QUERY, 32'h8000_0000, 3'd0, 32'h0);             // one row, at its own time
    send(OP_QUERY, 32'h7FFF_FFFF, 3'd0, 32'h0);             // held above
    send(OP_APPEND, 32'h8000_0000, 3'd0, 32'h1);            // time not increasing
    send(OP_APPEND, 32'h7FFF_FFFF, 3'd0, 32'hFFFF_FFFF);
    send(OP_APPEND, 32'h0, 3'd1, 32'h7FFF_FFFF);
    send(OP_APPEND, 32'h0, 3'd2, 32'h8000_0000);
    send(OP_QUERY, 32'h0, 3'd7, 32'hFFFF_FFFF);
    send(OP_QUERY, 32'h7FFF_FFFF, 3'd0, 32'h0);             // on the last breakpoint
    send(OP_QUERY, 32'h8000_0000, 3'd0, 32'h0);             // on the first breakpoint
    send(OP_NONE, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);      // dropped, no result
    send(OP_CLEAR, 32'h0, 3'd0, 32'h0);
    send(OP_QUERY, 32'h0, 3'd0, 32'h0);
    send(OP_APPEND, 32'h0, 3'd0, 32'h0001_0000);
    send(OP_APPEND, 32'h0, 3'd1, 32'h7FFF_FFFF);
    send(OP_APPEND, 32'h0, 3'd2, 32'h8000_0000);
    send(OP_QUERY, 32'h8000_0000, 3'd0, 32'h0);             // held below
    drain();
    write_cfg(REG_EXTRAP_ERR, 4'd1);
    send(OP_QUERY, 32'hFFFF_FFFB, 3'd0, 32'h0);             // range error
    send(OP_QUERY, 32'h0, 3'd0, 32'h0);
    drain();

    // Fill the table with one-unit steps and swinging samples: slope clips, then full.
    write_cfg(REG_ACTIVE_CH, 4'd1);
    write_cfg(REG_EXTRAP_ERR, 4'd0);
    for (int r = 0; r <= MAX_ROWS; r++)
      send(OP_APPEND, 32'(r), 3'd0, r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    send(OP_QUERY, 32'd100, 3'd0, 32'h0);
    send(OP_QUERY, 32'hFFFF_0000, 3'd0, 32'h0);
    drain();

    // Random phases over several register settings and idling mixes.
    write_cfg(REG_ACTIVE_CH, 4'd8);
    random_phase(RAND_ITEMS);
    send_idle = 79;
    recv_idle = 13;
    write_cfg(REG_ACTIVE_CH, 4'd0);                          // clamps to one channel
    write_cfg(REG_EXTRAP_ERR, 4'd1);
    random_phase(RAND_ITEMS);
    send_idle = 0;
    recv_idle = 0;
    write_cfg(REG_ACTIVE_CH, 4'd15);                         // clamps to the top
    write_cfg(REG_EXTRAP_ERR, 4'd0);
    random_phase(RAND_ITEMS);
    write_cfg(REG_ACTIVE_CH, 4'($urandom_range(2, 7)));
    write_cfg(REG_EXTRAP_ERR, 4'($urandom_range(1)));
    random_phase(RAND_ITEMS);

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("piecewise_linear_time_table_top_tb OK");
    end else begin
      $display("piecewise_linear_time_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule
